[rtl/fgm_pkg.sv]
// ----------------------------------------------------------------------------
// fgm_pkg
// Shared types and constants of the four-input gain mixer: register map,
// reset values, mode flag positions and fixed-point constants.
// ----------------------------------------------------------------------------
package fgm_pkg;

  localparam int SAMPLE_BITS_DEF = 16;

  // configuration port
  localparam int CFG_W = 17;
  localparam int IDX_W = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_MASTER_KNOB = 3'd0,
    REG_KNOB_A      = 3'd1,
    REG_KNOB_B      = 3'd2,
    REG_KNOB_C      = 3'd3,
    REG_KNOB_D      = 3'd4,
    REG_MODE_FLAGS  = 3'd5,
    REG_CLIP_LIMIT  = 3'd6
  } cfg_reg_t;

  localparam logic [15:0] KNOB_RST = 16'd16384;
  localparam logic [16:0] MODE_RST = 17'd112;
  localparam logic [14:0] CLIP_RST = 15'd24576;

  // mode flag bit positions
  localparam int INV_LSB   = 0;
  localparam int NORM_LSB  = 4;
  localparam int UNITY_BIT = 7;
  localparam int CONN_LSB  = 8;
  localparam int MCV_BIT   = 12;
  localparam int CV_LSB    = 13;

  // gain arithmetic
  localparam int          GAIN_MAX_X = 163840;   // 5 * 2.0 in Q2.14
  localparam int          YW         = 18;
  localparam int          GW         = 16;
  localparam int          GSW        = GW + 1;
  localparam logic [15:0] RECIP5     = 16'd52429;
  localparam int          RECIP5_SH  = 18;

  // output rounding and mix divisor
  localparam int          ROUND_SH   = 14;
  localparam int          MIX_SH     = 28;
  localparam int          TW         = 17;
  localparam logic [15:0] RECIP3     = 16'd43691;
  localparam int          RECIP3_SH  = 17;

  localparam int NSTG = 8;

endpackage

[rtl/four_input_gain_mixer_top.sv]
// ----------------------------------------------------------------------------
// four_input_gain_mixer_top
// Four-input gain mixer: per-input gain from knob and CV, scaled outputs
// and a master-scaled sum or average mix, all clipped symmetrically.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid/in_ready carry one poly slot per item (four
//   samples, valid mask, master cv and four gain cvs).
//   output channel: out_valid/out_ready carry out_a..out_d and mix_out.
//   config: cfg_we writes cfg_data into register cfg_index;
//   write only while no item is in flight.
//   pipeline: 8 register stages lie between accept and out_valid (cv
//   select and clamp, divide by 5, gain product, rounding and sum, master
//   product, mix scaling, divide by 3, final clip).
//   throughput: one item per cycle when not stalled; each stage advances
//   when the next stage is empty or moving, so bubbles are squeezed out.
//   reset: rst clears all stage valid bits and loads the register defaults
//   (knobs 1.0, normalize B-D on, clip 12 V).
//   stall: with out_ready low the last item holds on the outputs and the
//   pipeline keeps filling; in_ready drops only once every stage is full.
// ----------------------------------------------------------------------------
module four_input_gain_mixer_top #(
  parameter int SAMPLE_BITS = fgm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fgm_pkg::IDX_W-1:0]     cfg_index,
  input  logic [fgm_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_a,
  input  logic signed [SAMPLE_BITS-1:0] sample_b,
  input  logic signed [SAMPLE_BITS-1:0] sample_c,
  input  logic signed [SAMPLE_BITS-1:0] sample_d,
  input  logic [3:0]                    sample_valid,
  input  logic signed [SAMPLE_BITS-1:0] master_cv,
  input  logic signed [SAMPLE_BITS-1:0] cv_a,
  input  logic signed [SAMPLE_BITS-1:0] cv_b,
  input  logic signed [SAMPLE_BITS-1:0] cv_c,
  input  logic signed [SAMPLE_BITS-1:0] cv_d,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_a,
  output logic signed [SAMPLE_BITS-1:0] out_b,
  output logic signed [SAMPLE_BITS-1:0] out_c,
  output logic signed [SAMPLE_BITS-1:0] out_d,
  output logic signed [SAMPLE_BITS-1:0] mix_out
);
  import fgm_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int XW = (SB + 5 > 21) ? SB + 5 : 21;
  localparam int PW = SB + GSW;
  localparam int SW = PW + 2;
  localparam int RW = PW - ROUND_SH + 1;
  localparam int CW = (RW > TW + 1) ? RW : TW + 1;
  localparam int MW = SW + GSW;

  // configuration registers
  logic [15:0] master_knob;
  logic [15:0] knob [4];
  logic [16:0] mode_flags;
  logic [14:0] clip_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      master_knob <= KNOB_RST;
      for (int i = 0; i < 4; i++) knob[i] <= KNOB_RST;
      mode_flags  <= MODE_RST;
      clip_limit  <= CLIP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MASTER_KNOB: master_knob <= cfg_data[15:0];
        REG_KNOB_A:      knob[0]     <= cfg_data[15:0];
        REG_KNOB_B:      knob[1]     <= cfg_data[15:0];
        REG_KNOB_C:      knob[2]     <= cfg_data[15:0];
        REG_KNOB_D:      knob[3]     <= cfg_data[15:0];
        REG_MODE_FLAGS:  mode_flags  <= cfg_data;
        REG_CLIP_LIMIT:  clip_limit  <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  function automatic logic [YW-1:0] gain_x(input logic [15:0] k_in,
                                           input logic signed [SB-1:0] cv);
    logic signed [XW-1:0] k;
    logic signed [XW-1:0] c;
    logic signed [XW-1:0] x;
    k = XW'($signed({1'b0, k_in}));
    c = XW'(cv);
    x = (k <<< 2) + k + (c <<< 3);
    if (x < 0) return '0;
    else if (x > GAIN_MAX_X) return YW'(GAIN_MAX_X);
    else return x[YW-1:0];
  endfunction

  function automatic logic [GW-1:0] div5(input logic [YW-1:0] y);
    logic [YW+15:0] p;
    p = y * RECIP5;
    return p[RECIP5_SH +: GW];
  endfunction

  function automatic logic signed [RW-1:0] round14(input logic signed [PW-1:0] p);
    logic [PW-1:0] mag;
    logic [PW-1:0] q;
    logic signed [RW-1:0] r;
    mag = (p < 0) ? PW'(-p) : PW'(p);
    q   = (mag + (PW'(1) << (ROUND_SH - 1))) >> ROUND_SH;
    r   = $signed(q[RW-1:0]);
    return (p < 0) ? -r : r;
  endfunction

  function automatic logic signed [CW-1:0] clip(input logic signed [CW-1:0] v,
                                                input logic [14:0] lim_in);
    logic signed [CW-1:0] lim;
    lim = CW'($signed({1'b0, lim_in}));
    if (v > lim) return lim;
    else if (v < -lim) return -lim;
    else return v;
  endfunction

  // handshake: per-stage advance
  logic [NSTG:1] v;
  logic [NSTG:1] en;

  always_comb begin
    en[NSTG] = !v[NSTG] || out_ready;
    for (int k = NSTG - 1; k >= 1; k--) en[k] = !v[k] || en[k+1];
  end

  assign in_ready  = en[1];
  assign out_valid = v[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= in_valid;
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 1: cv selection and gain clamp
  logic signed [SB-1:0] smp_in [4];
  logic signed [SB-1:0] cv_in  [4];
  logic signed [SB-1:0] cv_res [4];
  logic signed [SB-1:0] mcv_res;

  assign smp_in[0] = sample_a;
  assign smp_in[1] = sample_b;
  assign smp_in[2] = sample_c;
  assign smp_in[3] = sample_d;
  assign cv_in[0]  = cv_a;
  assign cv_in[1]  = cv_b;
  assign cv_in[2]  = cv_c;
  assign cv_in[3]  = cv_d;

  always_comb begin
    cv_res[0] = mode_flags[CV_LSB] ? cv_in[0] : '0;
    for (int i = 1; i < 4; i++) begin
      if (mode_flags[CV_LSB+i]) cv_res[i] = cv_in[i];
      else if (mode_flags[NORM_LSB+i-1]) cv_res[i] = cv_res[i-1];
      else cv_res[i] = '0;
    end
    mcv_res = mode_flags[MCV_BIT] ? master_cv : '0;
  end

  logic [YW-1:0]        y1 [4];
  logic [YW-1:0]        ym1;
  logic signed [SB-1:0] s1 [4];
  logic [3:0]           sv1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 4; i++) begin
        y1[i] <= gain_x(knob[i], cv_res[i]);
        s1[i] <= smp_in[i];
      end
      ym1 <= gain_x(master_knob, mcv_res);
      sv1 <= sample_valid & mode_flags[CONN_LSB +: 4];
    end
  end

  // stage 2: divide by 5, round half up
  logic [GW-1:0]        g2 [4];
  logic [GW-1:0]        gm2;
  logic signed [SB-1:0] s2 [4];
  logic [3:0]           sv2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 4; i++) begin
        g2[i] <= div5(y1[i] + YW'(2));
        s2[i] <= s1[i];
      end
      gm2 <= div5(ym1 + YW'(2));
      sv2 <= sv1;
    end
  end

  // stage 3: signed gain times sample
  logic signed [GSW-1:0] gs [4];
  logic signed [PW-1:0]  p3 [4];
  logic [GW-1:0]         gm3;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      gs[i] = $signed({1'b0, g2[i]});
      if (mode_flags[INV_LSB+i]) gs[i] = -gs[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 4; i++) begin
        if (sv2[i]) p3[i] <= PW'(s2[i]) * PW'(gs[i]);
        else p3[i] <= '0;
      end
      gm3 <= gm2;
    end
  end

  // stage 4: per-output rounding, full precision sum
  logic signed [RW-1:0] r4 [4];
  logic signed [SW-1:0] sum4;
  logic [GW-1:0]        gm4;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < 4; i++) r4[i] <= round14(p3[i]);
      sum4 <= SW'(p3[0]) + SW'(p3[1]) + SW'(p3[2]) + SW'(p3[3]);
      gm4  <= gm3;
    end
  end

  // stage 5: output clip, master gain product
  logic signed [CW-1:0] o5 [4];
  logic signed [MW-1:0] mp5;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int i = 0; i < 4; i++) o5[i] <= clip(CW'(r4[i]), clip_limit);
      mp5 <= MW'(sum4) * MW'($signed({1'b0, gm4}));
    end
  end

  // stage 6: mix rounding to a count of 1/n steps
  logic [2:0]    n_conn;
  logic [2:0]    n_div;
  logic [MW-1:0] mag6;
  logic [MW-1:0] tf6;

  always_comb begin
    n_conn = 3'($countones(mode_flags[CONN_LSB +: 4]));
    n_div  = mode_flags[UNITY_BIT] ? 3'd1 : n_conn;
    mag6   = (mp5 < 0) ? MW'(-mp5) : MW'(mp5);
    tf6    = (mag6 + (MW'(n_div) << (MIX_SH - 1))) >> MIX_SH;
  end

  logic [TW-1:0]        t6;
  logic                 neg6;
  logic                 nz6;
  logic [2:0]           nd6;
  logic signed [CW-1:0] o6 [4];

  always_ff @(posedge clk) begin
    if (en[6]) begin
      t6   <= (tf6 > MW'({TW{1'b1}})) ? {TW{1'b1}} : tf6[TW-1:0];
      neg6 <= mp5 < 0;
      nz6  <= n_conn != 3'd0;
      nd6  <= n_div;
      o6   <= o5;
    end
  end

  // stage 7: reciprocal product for the divide by 3
  logic [TW+16:0]       t3_7;
  logic [TW-1:0]        t7;
  logic                 neg7;
  logic                 nz7;
  logic [2:0]           nd7;
  logic signed [CW-1:0] o7 [4];

  always_ff @(posedge clk) begin
    if (en[7]) begin
      t3_7 <= t6 * RECIP3;
      t7   <= t6;
      neg7 <= neg6;
      nz7  <= nz6;
      nd7  <= nd6;
      o7   <= o6;
    end
  end

  // stage 8: quotient select, sign and final clip
  logic [TW-1:0]        q8;
  logic signed [CW-1:0] mixv8;

  always_comb begin
    case (nd7)
      3'd1:    q8 = t7;
      3'd2:    q8 = t7 >> 1;
      3'd3:    q8 = t3_7[RECIP3_SH +: TW];
      3'd4:    q8 = t7 >> 2;
      default: q8 = '0;
    endcase
    mixv8 = $signed(CW'(q8));
    if (neg7) mixv8 = -mixv8;
  end

  logic signed [CW-1:0] o8 [4];
  logic signed [CW-1:0] mix8;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      o8   <= o7;
      mix8 <= nz7 ? clip(mixv8, clip_limit) : '0;
    end
  end

  assign out_a   = o8[0][SB-1:0];
  assign out_b   = o8[1][SB-1:0];
  assign out_c   = o8[2][SB-1:0];
  assign out_d   = o8[3][SB-1:0];
  assign mix_out = mix8[SB-1:0];

endmodule

[rtl/fgm_checker.sv]
// ----------------------------------------------------------------------------
// fgm_checker
// Port-level checks of the gain mixer: output hold under stall, reset
// behavior and the relation of in_ready to the output stall.
// ----------------------------------------------------------------------------
module fgm_checker #(
  parameter int SAMPLE_BITS = fgm_pkg::SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] out_a,
  input logic signed [SAMPLE_BITS-1:0] out_b,
  input logic signed [SAMPLE_BITS-1:0] out_c,
  input logic signed [SAMPLE_BITS-1:0] out_d,
  input logic signed [SAMPLE_BITS-1:0] mix_out
);
  import fgm_pkg::*;

  a_out_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_a) && $stable(out_b) && $stable(out_c)
      && $stable(out_d) && $stable(mix_out))
    else $error("output item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without an output stall");

endmodule

bind four_input_gain_mixer_top fgm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_fgm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_a     (out_a),
  .out_b     (out_b),
  .out_c     (out_c),
  .out_d     (out_d),
  .mix_out   (mix_out)
);

[tb/sv/four_input_gain_mixer_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_input_gain_mixer_top_tb
// Self-checking bench for the four-input gain mixer. A short directed table
// covers reset values, sample, cv and knob extremes, rounding halves,
// inversion, cv normalization, averaging divisors and clipping. Random phases
// with random register settings follow. Every accepted item is checked field
// by field against its gold value or, lacking one, an in-place prediction,
// under random stalls on both channels except in the last three phases.
// ----------------------------------------------------------------------------
module four_input_gain_mixer_top_tb;
  import fgm_pkg::*;

  localparam int SB              = SAMPLE_BITS_DEF;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 12;
  localparam int RAND_PHASES     = 9;
  localparam int ITEMS_PER_PHASE = 80;

  localparam logic [CFG_W-1:0] M_INV_ALL  = 17'hF << INV_LSB;
  localparam logic [CFG_W-1:0] M_NORM_ALL = 17'h7 << NORM_LSB;
  localparam logic [CFG_W-1:0] M_NORM_B   = 17'h1 << NORM_LSB;
  localparam logic [CFG_W-1:0] M_UNITY    = 17'h1 << UNITY_BIT;
  localparam logic [CFG_W-1:0] M_CONN_ALL = 17'hF << CONN_LSB;
  localparam logic [CFG_W-1:0] M_CONN_ABC = 17'h7 << CONN_LSB;
  localparam logic [CFG_W-1:0] M_CONN_AB  = 17'h3 << CONN_LSB;
  localparam logic [CFG_W-1:0] M_MCV      = 17'h1 << MCV_BIT;
  localparam logic [CFG_W-1:0] M_CV_ALL   = 17'hF << CV_LSB;
  localparam logic [CFG_W-1:0] M_CV_A     = 17'h1 << CV_LSB;
  localparam logic [CFG_W-1:0] M_ALL_ON   = 17'h1FFFF;

  typedef logic signed [SB-1:0] s16_t;

  typedef struct packed {
    s16_t [3:0] smp;
    logic [3:0] valid;
    s16_t       mcv;
    s16_t [3:0] cv;
  } slot_t;

  typedef struct packed {
    s16_t [3:0] ch;
    s16_t       mix;
  } mix_result_t;

  typedef struct packed {
    logic             is_cfg;
    cfg_reg_t         reg_id;
    logic [CFG_W-1:0] value;
    slot_t            slot;
    logic             has_gold;
    mix_result_t      gold;
  } stim_row_t;

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             cfg_we       = 1'b0;
  logic [IDX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0] cfg_data     = '0;
  logic             in_valid     = 1'b0;
  logic             in_ready;
  s16_t             sample_a     = '0;
  s16_t             sample_b     = '0;
  s16_t             sample_c     = '0;
  s16_t             sample_d     = '0;
  logic [3:0]       sample_valid = '0;
  s16_t             master_cv    = '0;
  s16_t             cv_a         = '0;
  s16_t             cv_b         = '0;
  s16_t             cv_c         = '0;
  s16_t             cv_d         = '0;
  logic             out_valid;
  logic             out_ready    = 1'b0;
  s16_t             out_a, out_b, out_c, out_d, mix_out;

  // predictor copy of the registers
  logic [15:0]      knob_q14 [4];
  logic [15:0]      master_q14;
  logic [CFG_W-1:0] mode_q;
  logic [14:0]      clip_q;

  mix_result_t expected_mix_q [$];
  stim_row_t   stim_rows [$];

  int src_idle_pct    = 0;
  int snk_idle_pct    = 0;
  int items_sent      = 0;
  int directed_items  = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int cfg_writes      = 0;
  int idle_cycles     = 0;

  four_input_gain_mixer_top #(.SAMPLE_BITS(SB)) dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .sample_a(sample_a), .sample_b(sample_b), .sample_c(sample_c), .sample_d(sample_d),
    .sample_valid(sample_valid), .master_cv(master_cv),
    .cv_a(cv_a), .cv_b(cv_b), .cv_c(cv_c), .cv_d(cv_d),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_a(out_a), .out_b(out_b), .out_c(out_c), .out_d(out_d), .mix_out(mix_out)
  );

  always #5 clk = ~clk;

  function automatic longint gain_q14(longint knob, longint cv_v);
    longint x;
    x = knob * 5 + cv_v * 8;
    if (x < 0) x = 0;
    if (x > GAIN_MAX_X) x = GAIN_MAX_X;
    return (x + 2) / 5;
  endfunction

  function automatic longint round_half_away(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic s16_t clip_to_limit(longint v);
    longint lim;
    lim = longint'(clip_q);
    if (v > lim) return s16_t'(lim);
    if (v < -lim) return s16_t'(-lim);
    return s16_t'(v);
  endfunction

  function automatic mix_result_t predict_mix(slot_t sl);
    mix_result_t r;
    longint      g [4];
    longint      cv_sel, prod, sum, master, cv_m;
    int          n;
    cv_sel = 0;
    sum = 0;
    n = 0;
    for (int i = 0; i < 4; i++) begin
      if (mode_q[CV_LSB + i]) begin
        cv_sel = longint'($signed(sl.cv[i]));
      end else if (i == 0 || !mode_q[NORM_LSB + i - 1]) begin
        cv_sel = 0;
      end
      g[i] = gain_q14(longint'(knob_q14[i]), cv_sel);
      if (mode_q[INV_LSB + i]) g[i] = -g[i];
    end
    for (int i = 0; i < 4; i++) begin
      r.ch[i] = '0;
      if (mode_q[CONN_LSB + i]) begin
        n++;
        if (sl.valid[i]) begin
          prod = longint'($signed(sl.smp[i])) * g[i];
          sum += prod;
          r.ch[i] = clip_to_limit(round_half_away(prod, longint'(1) << ROUND_SH));
        end
      end
    end
    r.mix = '0;
    if (n != 0) begin
      cv_m = mode_q[MCV_BIT] ? longint'($signed(sl.mcv)) : 0;
      master = gain_q14(longint'(master_q14), cv_m);
      if (mode_q[UNITY_BIT]) n = 1;
      r.mix = clip_to_limit(round_half_away(sum * master, longint'(n) << MIX_SH));
    end
    return r;
  endfunction

  function automatic s16_t rand_sample();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2, 3: return s16_t'($urandom);
      default: return s16_t'(int'($urandom_range(8000)) - 4000);
    endcase
  endfunction

  function automatic s16_t rand_cv();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return s16_t'($urandom);
      default: return s16_t'(int'($urandom_range(24000)) - 12000);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_knob();
    case ($urandom_range(9))
      0: return '0;
      1: return 17'd32768;
      2: return 17'hFFFF;
      3: return CFG_W'(KNOB_RST);
      default: return CFG_W'($urandom_range(32768));
    endcase
  endfunction

  task automatic add_slot(input int a, b, c, d, input logic [3:0] v,
                          input int m, ca, cb, cc, cd);
    stim_row_t row;
    row = '0;
    row.slot.smp[0] = s16_t'(a);
    row.slot.smp[1] = s16_t'(b);
    row.slot.smp[2] = s16_t'(c);
    row.slot.smp[3] = s16_t'(d);
    row.slot.valid = v;
    row.slot.mcv = s16_t'(m);
    row.slot.cv[0] = s16_t'(ca);
    row.slot.cv[1] = s16_t'(cb);
    row.slot.cv[2] = s16_t'(cc);
    row.slot.cv[3] = s16_t'(cd);
    stim_rows.push_back(row);
  endtask

  task automatic add_gold(input int a, b, c, d, mx);
    stim_row_t row;
    row = stim_rows[stim_rows.size() - 1];
    row.has_gold = 1'b1;
    row.gold.ch[0] = s16_t'(a);
    row.gold.ch[1] = s16_t'(b);
    row.gold.ch[2] = s16_t'(c);
    row.gold.ch[3] = s16_t'(d);
    row.gold.mix = s16_t'(mx);
    stim_rows[stim_rows.size() - 1] = row;
  endtask

  task automatic add_reg(input cfg_reg_t r, input logic [CFG_W-1:0] v);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.reg_id = r;
    row.value = v;
    stim_rows.push_back(row);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (r)
      REG_MASTER_KNOB: master_q14 = v[15:0];
      REG_KNOB_A:      knob_q14[0] = v[15:0];
      REG_KNOB_B:      knob_q14[1] = v[15:0];
      REG_KNOB_C:      knob_q14[2] = v[15:0];
      REG_KNOB_D:      knob_q14[3] = v[15:0];
      REG_MODE_FLAGS:  mode_q = v;
      REG_CLIP_LIMIT:  clip_q = v[14:0];
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic drain_pipe();
    while (expected_mix_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_slot(input slot_t sl, input logic has_gold, input mix_result_t gold);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_a <= sl.smp[0];
    sample_b <= sl.smp[1];
    sample_c <= sl.smp[2];
    sample_d <= sl.smp[3];
    sample_valid <= sl.valid;
    master_cv <= sl.mcv;
    cv_a <= sl.cv[0];
    cv_b <= sl.cv[1];
    cv_c <= sl.cv[2];
    cv_d <= sl.cv[3];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_mix_q.push_back(has_gold ? gold : predict_mix(sl));
    items_sent++;
  endtask

  always @(posedge clk) begin : result_check
    mix_result_t got, want;
    if (!rst && out_valid && out_ready) begin
      got.ch[0] = out_a;
      got.ch[1] = out_b;
      got.ch[2] = out_c;
      got.ch[3] = out_d;
      got.mix = mix_out;
      if (expected_mix_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t unexpected item: a %0d b %0d c %0d d %0d mix %0d",
                   $realtime, out_a, out_b, out_c, out_d, mix_out);
      end else begin
        want = expected_mix_q.pop_front();
        results_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t mismatch exp a %0d b %0d c %0d d %0d mix %0d / got %0d %0d %0d %0d %0d",
                     $realtime, want.ch[0], want.ch[1], want.ch[2], want.ch[3], want.mix,
                     out_a, out_b, out_c, out_d, mix_out);
        end
      end
    end
    out_ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    stim_row_t        row;
    slot_t            sl;
    logic [CFG_W-1:0] mode_v, clip_v;

    master_q14 = KNOB_RST;
    for (int i = 0; i < 4; i++) knob_q14[i] = KNOB_RST;
    mode_q = MODE_RST;
    clip_q = CLIP_RST;

    // reset defaults: nothing connected
    add_slot(32767, 32767, 32767, 32767, 4'hF, 32767, 32767, 32767, 32767, 32767);
    add_gold(0, 0, 0, 0, 0);
    add_slot(-32768, -32768, -32768, -32768, 4'hF, -32768, -32768, -32768, -32768, -32768);
    add_gold(0, 0, 0, 0, 0);
    // unity gains, sum mode
    add_reg(REG_MODE_FLAGS, M_CONN_ALL | M_UNITY);
    add_slot(1000, -2000, 3000, 0, 4'hF, 0, 0, 0, 0, 0);
    add_gold(1000, -2000, 3000, 0, 2000);
    add_slot(32767, -32768, 0, 0, 4'hF, 32767, 32767, -32768, 5, 5);
    add_gold(24576, -24576, 0, 0, -1);
    add_slot(5000, 5000, 5000, 5000, 4'h0, 0, 0, 0, 0, 0);
    add_gold(0, 0, 0, 0, 0);
    add_slot(100, 200, 300, 400, 4'b0101, 0, 0, 0, 0, 0);
    add_gold(100, 0, 300, 0, 400);
    add_reg(REG_CLIP_LIMIT, '0);
    add_slot(12345, -1, 1, -32768, 4'hF, 0, 0, 0, 0, 0);
    add_gold(0, 0, 0, 0, 0);
    add_reg(REG_CLIP_LIMIT, 17'h7FFF);
    add_slot(32767, -32768, 32767, -32768, 4'hF, 0, 0, 0, 0, 0);
    add_gold(32767, -32767, 32767, -32767, -2);
    // half, double, saturated and zero knobs; rounding halves
    add_reg(REG_KNOB_A, 17'd8192);
    add_reg(REG_KNOB_B, 17'd32768);
    add_reg(REG_KNOB_C, 17'hFFFF);
    add_reg(REG_KNOB_D, '0);
    add_slot(1, -1, 3, 100, 4'hF, 0, 0, 0, 0, 0);
    add_slot(-1, 20000, -20000, 5, 4'hF, 0, 0, 0, 0, 0);
    // inverted, cv driven, averaging over four
    add_reg(REG_MODE_FLAGS, M_INV_ALL | M_NORM_ALL | M_CONN_ALL | M_MCV | M_CV_ALL);
    add_slot(1000, -1000, 500, -500, 4'hF, 0, 32767, 32767, 32767, 32767);
    add_slot(1000, -1000, 500, -500, 4'hF, 0, -32768, -32768, -32768, -32768);
    add_slot(3000, 2000, 1000, -4000, 4'hF, -32768, 1234, -2345, 3456, -4567);
    add_slot(3000, 2000, 1000, -4000, 4'hF, 32767, 1234, -2345, 3456, -4567);
    // cv normalization chain from input a
    add_reg(REG_MODE_FLAGS, M_CV_A | M_NORM_ALL | M_CONN_ALL);
    add_slot(1000, 1000, 1000, 1000, 4'hF, 0, 10240, 0, 0, 0);
    add_reg(REG_MODE_FLAGS, M_CV_A | M_NORM_B | M_CONN_ALL);
    add_slot(1000, 1000, 1000, 1000, 4'hF, 0, 10240, 0, 0, 0);
    // averaging over three and two, connected but not valid still counts
    add_reg(REG_MODE_FLAGS, M_CONN_ABC);
    add_slot(3000, 3000, 3001, 7, 4'hF, 0, 0, 0, 0, 0);
    add_slot(3000, 3000, 3001, 7, 4'b0001, 0, 0, 0, 0, 0);
    add_reg(REG_MODE_FLAGS, M_CONN_AB);
    add_slot(-7001, 2, 9, 9, 4'hF, 0, 0, 0, 0, 0);
    // master knob zero and above range
    add_reg(REG_MASTER_KNOB, '0);
    add_slot(1000, 1000, 1000, 1000, 4'hF, 0, 0, 0, 0, 0);
    add_reg(REG_MASTER_KNOB, 17'hFFFF);
    add_slot(1000, 1000, 1000, 1000, 4'hF, 0, 0, 0, 0, 0);
    add_reg(REG_MODE_FLAGS, M_ALL_ON);
    add_slot(-32768, 32767, -12345, 12345, 4'hF, 32767, -1, 1, 0, -32768);
    add_reg(REG_MODE_FLAGS, '0);
    add_slot(-32768, 32767, -12345, 12345, 4'hF, 32767, -1, 1, 0, -32768);
    add_gold(0, 0, 0, 0, 0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct = 9;
    snk_idle_pct = 70;
    for (int k = 0; k < stim_rows.size(); k++) begin
      row = stim_rows[k];
      if (row.is_cfg) begin
        if (k == 0 || !stim_rows[k - 1].is_cfg) begin
          in_valid <= 1'b0;
          drain_pipe();
        end
        write_reg(row.reg_id, row.value);
      end else begin
        send_slot(row.slot, row.has_gold, row.gold);
      end
    end
    directed_items = items_sent;

    for (int p = 0; p < RAND_PHASES; p++) begin
      src_idle_pct = (p < 3) ? 9 : (p < 6) ? 70 : 0;
      snk_idle_pct = (p < 3) ? 70 : (p < 6) ? 9 : 0;
      in_valid <= 1'b0;
      drain_pipe();
      write_reg(REG_MASTER_KNOB, rand_knob());
      write_reg(REG_KNOB_A, rand_knob());
      write_reg(REG_KNOB_B, rand_knob());
      write_reg(REG_KNOB_C, rand_knob());
      write_reg(REG_KNOB_D, rand_knob());
      mode_v = CFG_W'($urandom);
      if ($urandom_range(3) != 0) mode_v[CONN_LSB +: 4] = 4'hF;
      write_reg(REG_MODE_FLAGS, mode_v);
      case ($urandom_range(9))
        0: clip_v = '0;
        1: clip_v = 17'h7FFF;
        2: clip_v = CLIP_RST;
        default: clip_v = CFG_W'($urandom_range(32767));
      endcase
      write_reg(REG_CLIP_LIMIT, clip_v);
      for (int j = 0; j < ITEMS_PER_PHASE; j++) begin
        for (int i = 0; i < 4; i++) begin
          sl.smp[i] = rand_sample();
          sl.cv[i] = rand_cv();
        end
        sl.valid = 4'($urandom_range(15));
        sl.mcv = rand_cv();
        send_slot(sl, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;
    drain_pipe();

    $display("covered %0d items (%0d directed) under %0d register settings, %0d writes",
             items_sent, directed_items, RAND_PHASES, cfg_writes);
    $display("%0d results checked, %0d mismatches, %0d results missing",
             results_checked, mismatches, expected_mix_q.size());
    if (mismatches == 0 && expected_mix_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/fgm_pkg.sv
rtl/four_input_gain_mixer_top.sv
rtl/fgm_checker.sv
tb/sv/four_input_gain_mixer_top_tb.sv
